[src/swda_pkg.sv]
// shared types, widths and constants for the sliding window duration average
// no dependencies; used by all modules but swda_ram, by scoped names
`timescale 1ns / 1ps
`default_nettype none

package swda_pkg;

    // default build values for the top level and datapath parameters
    localparam int WINDOW_DEPTH_DEFAULT = 256;
    localparam int SAMPLE_BITS_DEFAULT  = 32;

    // fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 9;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 63;
    localparam int MEAN_W   = 40;
    localparam int FRAC_W   = 8;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_FIELD_W = COUNT_W + SUM_W + MEAN_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // divider: quotient bits left once the high part of the sum is below the count
    localparam int DIV_STEPS = (SUM_W - COUNT_W) + 1 + FRAC_W;
    localparam int DIV_SH_W  = SUM_W - (SUM_W - COUNT_W) + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = {{(MEAN_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_ADD,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic drop_step;
        logic add_step;
        logic div_start;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

[src/swda_ram.sv]
// generic single write port ram with a registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module swda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[src/swda_div.sv]
// iterative restoring divider for the q8 mean, one quotient bit per cycle
// depends on swda_pkg
`timescale 1ns / 1ps
`default_nettype none

module swda_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [swda_pkg::SUM_W-1:0]     dividend,
    input  wire logic [swda_pkg::COUNT_W-1:0]   divisor,
    output logic                                done,
    output logic      [swda_pkg::MEAN_W-1:0]    quotient
);

    localparam int HI_W = swda_pkg::SUM_W - swda_pkg::COUNT_W;

    logic                              busy_reg;
    logic                              done_reg;
    logic [swda_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [swda_pkg::COUNT_W-1:0]      rem_reg;
    logic [swda_pkg::COUNT_W-1:0]      den_reg;
    logic [swda_pkg::DIV_SH_W-1:0]     sh_reg;

    logic [swda_pkg::COUNT_W:0]        trial;
    logic [swda_pkg::COUNT_W:0]        diff;
    logic                              fits;
    logic                              ovf;

    // integer part above 32 bits when the high part of the sum reaches the count
    assign ovf   = {1'b0, dividend[swda_pkg::SUM_W-1:swda_pkg::COUNT_W]} >= divisor;
    assign trial = {rem_reg, sh_reg[swda_pkg::DIV_SH_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !ovf;
                done_reg <= ovf;
                cnt_reg  <= swda_pkg::DIV_CNT_W'(swda_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= {1'b0, dividend[swda_pkg::SUM_W-1:swda_pkg::COUNT_W]};
            if (ovf)
            begin
                sh_reg <= swda_pkg::MEAN_MAX;
            end
            else
            begin
                sh_reg <= {dividend[swda_pkg::COUNT_W-1:0], {swda_pkg::FRAC_W{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[swda_pkg::COUNT_W-1:0] : trial[swda_pkg::COUNT_W-1:0];
            sh_reg  <= {sh_reg[swda_pkg::DIV_SH_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

    // the high part of the sum seeds the remainder
    if (HI_W >= swda_pkg::COUNT_W)
    begin : g_bad_width
        $error("sum high part must be narrower than the count");
    end

endmodule

`default_nettype wire

[src/swda_datapath.sv]
// ring store, running count and sum, divider and output register
// depends on swda_pkg, swda_ram and swda_div
`timescale 1ns / 1ps
`default_nettype none

module swda_datapath #(
    parameter int WINDOW_DEPTH = swda_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS  = swda_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swda_pkg::WLEN_W-1:0]     cfg_wr_data,
    input  wire logic [swda_pkg::SAMPLE_W-1:0]   sample,
    input  wire swda_pkg::cmd_t                  cmd,
    output swda_pkg::status_t                    status,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [swda_pkg::M_TDATA_W-1:0]  out_data
);

    localparam int IDX_BITS = $clog2(WINDOW_DEPTH);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(WINDOW_DEPTH - 1);
    localparam logic [IDX_BITS-1:0] FIRST_NEXT = IDX_BITS'(1);
    localparam logic [swda_pkg::COUNT_W-1:0] DEPTH_CNT = swda_pkg::COUNT_W'(WINDOW_DEPTH);

    logic [swda_pkg::WLEN_W-1:0]    window_len_reg;
    logic [IDX_BITS-1:0]            oldest_reg;
    logic [IDX_BITS-1:0]            next_reg;
    logic [swda_pkg::COUNT_W-1:0]   count_reg;
    logic [swda_pkg::SUM_W-1:0]     sum_reg;
    logic                           seed_reg;
    logic [SAMPLE_BITS-1:0]         sample_reg;

    logic                           out_valid_reg;
    logic [swda_pkg::COUNT_W-1:0]   out_count_reg;
    logic [swda_pkg::SUM_W-1:0]     out_sum_reg;
    logic [swda_pkg::MEAN_W-1:0]    out_mean_reg;

    logic [SAMPLE_BITS+swda_pkg::SAMPLE_W-1:0] sample_wide;
    logic [SAMPLE_BITS-1:0]         ring_rd;
    logic [swda_pkg::SUM_W-1:0]     old_val;
    logic [swda_pkg::SUM_W-1:0]     new_val;
    logic [swda_pkg::SUM_W:0]       sum_add;
    logic [swda_pkg::COUNT_W-1:0]   win_raw;
    logic [swda_pkg::COUNT_W-1:0]   win_eff;
    logic                           drop_now;
    logic                           div_done;
    logic [swda_pkg::MEAN_W-1:0]    quotient;

    // sample masked to the stored width
    assign sample_wide = {{SAMPLE_BITS{1'b0}}, sample};

    assign win_raw  = swda_pkg::COUNT_W'(window_len_reg);
    assign win_eff  = (win_raw > DEPTH_CNT) ? DEPTH_CNT : win_raw;
    assign drop_now = (win_eff != '0) && (count_reg >= win_eff);

    // the seed sample after restart was never written and reads as zero
    assign old_val = seed_reg ? '0 : {{(swda_pkg::SUM_W-SAMPLE_BITS){1'b0}}, ring_rd};
    assign new_val = {{(swda_pkg::SUM_W-SAMPLE_BITS){1'b0}}, sample_reg};
    assign sum_add = {1'b0, sum_reg} + {1'b0, new_val};

    swda_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.add_step),
        .wr_addr (next_reg),
        .wr_data (sample_reg),
        .rd_addr (oldest_reg),
        .rd_data (ring_rd)
    );

    swda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= '0;
            oldest_reg     <= '0;
            next_reg       <= FIRST_NEXT;
            count_reg      <= swda_pkg::COUNT_W'(1);
            sum_reg        <= '0;
            seed_reg       <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            window_len_reg <= cfg_wr_data;
            oldest_reg     <= '0;
            next_reg       <= FIRST_NEXT;
            count_reg      <= swda_pkg::COUNT_W'(1);
            sum_reg        <= '0;
            seed_reg       <= 1'b1;
        end
        else if (cmd.drop_step)
        begin
            if (drop_now)
            begin
                sum_reg    <= (sum_reg >= old_val) ? sum_reg - old_val : '0;
                oldest_reg <= (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
                count_reg  <= count_reg - 1'b1;
                seed_reg   <= 1'b0;
            end
        end
        else if (cmd.add_step)
        begin
            next_reg <= (next_reg == LAST_IDX) ? '0 : next_reg + 1'b1;
            if (count_reg != swda_pkg::COUNT_MAX)
            begin
                count_reg <= count_reg + 1'b1;
            end
            sum_reg <= sum_add[swda_pkg::SUM_W] ? swda_pkg::SUM_MAX
                                                : sum_add[swda_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_wide[SAMPLE_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_count_reg <= count_reg;
            out_sum_reg   <= sum_reg;
            out_mean_reg  <= quotient;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(swda_pkg::M_TDATA_W - swda_pkg::M_FIELD_W){1'b0}},
                        out_mean_reg, out_sum_reg, out_count_reg};

    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

[src/swda_ctrl.sv]
// sequencer: accept, drop, add, divide, hand over to the output register
// depends on swda_pkg
`timescale 1ns / 1ps
`default_nettype none

module swda_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire swda_pkg::status_t  status,
    output swda_pkg::cmd_t          cmd
);

    swda_pkg::state_t state_reg;
    swda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            swda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = swda_pkg::ST_DROP;
                end
            end
            swda_pkg::ST_DROP:
            begin
                cmd.drop_step = 1'b1;
                state_next    = swda_pkg::ST_ADD;
            end
            swda_pkg::ST_ADD:
            begin
                cmd.add_step = 1'b1;
                state_next   = swda_pkg::ST_START;
            end
            swda_pkg::ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = swda_pkg::ST_DIV;
            end
            swda_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = swda_pkg::ST_OUT;
                end
            end
            swda_pkg::ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = swda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/sliding_window_duration_average.sv]
// top level of the sliding window duration average
// depends on swda_pkg, swda_ctrl and swda_datapath (with swda_ram and swda_div)
//
// usage
//   slave stream (s_tvalid, s_tready, s_tdata) takes one duration sample per transfer
//   master stream (m_tvalid, m_tready, m_tdata) gives one result per sample: the
//   count of samples held, their sum and the mean in unsigned q8, truncated
//   cfg_wr_en / cfg_wr_data set the window length (0 means no limit, values above
//   the ring depth act as the depth); a write restarts the window to one zero
//   sample with a count of one; the user makes it only while the block is idle (unenforced)
// timing
//   one sample at a time: accept, drop of the oldest sample (ring read), add and
//   ring write, divider start, then one quotient bit per cycle in the bit-serial
//   divider, then the output register load; when the mean overflows 32 integer bits
//   the divider skips its steps and loads the saturated mean
// reset
//   rst_n clears the window to its restart state; the ring needs no clearing since
//   the only entry read before being written is the seed zero sample
// stalls
//   the result waits in the output register; the next sample is still accepted and
//   processed, and only its handover waits until m_tready takes the earlier one
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_duration_average #(
    parameter int WINDOW_DEPTH = swda_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS  = swda_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write
    input  wire logic                            cfg_wr_en,
    input  wire logic [swda_pkg::WLEN_W-1:0]     cfg_wr_data,   // window_len
    // sample stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [swda_pkg::S_TDATA_W-1:0]  s_tdata,       // sample[31:0]
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // sample_count[31:0], window_sum[94:32], mean_q8[134:95], zero pad[135]
    output logic      [swda_pkg::M_TDATA_W-1:0]  m_tdata
);

    swda_pkg::cmd_t    cmd;
    swda_pkg::status_t status;

    // sequencer
    swda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // ring store, count, sum, divider and output register
    swda_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

endmodule

`default_nettype wire
